// File: src/ert_pkg.sv
// Shared constants for the epoch round use tracker.
// No dependencies; imported by the count RAM and the top level.
`default_nettype none

package ert_pkg;

  // Field widths fixed by the request format
  localparam int ROUND_W   = 32;
  localparam int COUNT_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int RETIRED_W = 3;

  // Default sizing of the ring and of the retire burst
  localparam int ROUNDS_DEF       = 32;
  localparam int RETIRE_LIMIT_DEF = 4;

  // Operation codes
  localparam logic OP_ENTER = 1'b0;
  localparam logic OP_EXIT  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_LIVE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

  // Saturation value of a use count
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

// File: src/epoch_round_use_tracker.sv
// Epoch round use tracker: top level with the sequencer and the shared count unit.
// Depends on ert_pkg and ert_count_ram.
`default_nettype none

// The block keeps a ring of ROUNDS use counts, one per live reader round, in a
// one-read/one-write RAM, and handles one request at a time; in_stall is high
// from acceptance until the result is loaded into the output register. An enter
// steps through acceptance, status check with the read of the newest count,
// write of the new count, and result. An enter on a full ring and an exit for a
// round outside the live span go from the status check straight to the result.
// An exit walks every live slot (at most ROUNDS live rounds) from the oldest
// round, one slot per cycle through the RAM port, decrementing from the
// reader's round onward, then tests the oldest count (1 to RETIRE_LIMIT tests)
// with one read and one compare per test. Slots that are not live are never
// read, so the RAM needs no clearing after reset. The output register holds a
// result until it is taken; a finished request waits for it to free up before
// the result loads and the next request is accepted.

module epoch_round_use_tracker #(
  parameter int ROUNDS       = ert_pkg::ROUNDS_DEF,
  parameter int RETIRE_LIMIT = ert_pkg::RETIRE_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [ert_pkg::ROUND_W-1:0]   in_entered_round,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ert_pkg::ROUND_W-1:0]   out_round_id,
  output logic [ert_pkg::STATUS_W-1:0]  out_status,
  output logic [ert_pkg::RETIRED_W-1:0] out_rounds_retired,
  output logic [ert_pkg::ROUND_W-1:0]   out_oldest_live_round
);
  import ert_pkg::*;

  localparam int SW = $clog2(ROUNDS);            // slot index width
  localparam int LW = $clog2(ROUNDS + 1);        // live count width
  localparam int RW = $clog2(RETIRE_LIMIT + 1);  // retire counter width
  localparam logic [SW-1:0] SLOT_LAST  = SW'(ROUNDS - 1);
  localparam logic [LW-1:0] LIVE_FULL  = LW'(ROUNDS);
  localparam logic [RW-1:0] RET_LIMIT  = RW'(RETIRE_LIMIT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ENT_WR,
    S_WALK,
    S_RET_RD,
    S_RET_CHK,
    S_DONE
  } state_t;

  // Slot of round rnd+1 given the slot of rnd; ids wrap to slot zero.
  function automatic logic [SW-1:0] slot_step(input logic [ROUND_W-1:0] rnd,
                                               input logic [SW-1:0]      slot);
    logic [SW-1:0] res;
    if (rnd == '1 || slot == SLOT_LAST) begin
      res = '0;
    end else begin
      res = slot + 1'b1;
    end
    return res;
  endfunction

  state_t               state_r, state_nxt;
  logic                 op_r, op_nxt;
  logic [ROUND_W-1:0]   entered_r, entered_nxt;
  logic [ROUND_W-1:0]   newest_r, newest_nxt;
  logic [ROUND_W-1:0]   oldest_r, oldest_nxt;
  logic [SW-1:0]        newest_slot_r, newest_slot_nxt;
  logic [SW-1:0]        oldest_slot_r, oldest_slot_nxt;
  logic [LW-1:0]        live_r, live_nxt;
  logic [ROUND_W-1:0]   wk_round_r, wk_round_nxt;
  logic [SW-1:0]        wk_slot_r, wk_slot_nxt;
  logic [LW-1:0]        rem_r, rem_nxt;
  logic [LW-1:0]        skip_r, skip_nxt;
  logic                 pend_r, pend_nxt;
  logic [SW-1:0]        pend_slot_r, pend_slot_nxt;
  logic [ROUND_W-1:0]   res_round_r, res_round_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [RW-1:0]        retired_r, retired_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ROUND_W-1:0]   out_round_r, out_round_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [RETIRED_W-1:0] out_retired_r, out_retired_nxt;
  logic [ROUND_W-1:0]   out_oldest_r, out_oldest_nxt;

  // RAM port
  logic                 ram_rd_en;
  logic [SW-1:0]        ram_rd_addr;
  logic [COUNT_W-1:0]   ram_rd_data;
  logic                 ram_wr_en;
  logic [SW-1:0]        ram_wr_addr;
  logic [COUNT_W-1:0]   ram_wr_data;

  // shared count unit
  logic [COUNT_W-1:0]   alu_a;
  logic                 alu_inc;
  logic [COUNT_W-1:0]   alu_y;
  logic                 alu_clip;

  logic [ROUND_W-1:0]   ofs;

  ert_count_ram #(
    .DEPTH (ROUNDS),
    .AW    (SW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  // Saturating increment / decrement of one count
  always_comb begin
    alu_clip = 1'b0;
    if (alu_inc) begin
      if (alu_a == COUNT_MAX) begin
        alu_y    = COUNT_MAX;
        alu_clip = 1'b1;
      end else begin
        alu_y = alu_a + 1'b1;
      end
    end else begin
      if (alu_a == '0) begin
        alu_y    = '0;
        alu_clip = 1'b1;
      end else begin
        alu_y = alu_a - 1'b1;
      end
    end
  end

  // Distance of the named round from the oldest live round
  assign ofs = entered_r - oldest_r;

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    entered_nxt     = entered_r;
    newest_nxt      = newest_r;
    oldest_nxt      = oldest_r;
    newest_slot_nxt = newest_slot_r;
    oldest_slot_nxt = oldest_slot_r;
    live_nxt        = live_r;
    wk_round_nxt    = wk_round_r;
    wk_slot_nxt     = wk_slot_r;
    rem_nxt         = rem_r;
    skip_nxt        = skip_r;
    pend_nxt        = pend_r;
    pend_slot_nxt   = pend_slot_r;
    res_round_nxt   = res_round_r;
    status_nxt      = status_r;
    retired_nxt     = retired_r;
    out_valid_nxt   = out_valid_r;
    out_round_nxt   = out_round_r;
    out_status_nxt  = out_status_r;
    out_retired_nxt = out_retired_r;
    out_oldest_nxt  = out_oldest_r;
    ram_rd_en       = 1'b0;
    ram_rd_addr     = newest_slot_r;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = pend_slot_r;
    alu_a           = ram_rd_data;
    alu_inc         = 1'b0;

    // output register drains independently
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_operation;
          entered_nxt = in_entered_round;
          state_nxt   = S_CHECK;
        end
      end

      S_CHECK: begin
        status_nxt  = ST_OK;
        retired_nxt = '0;
        if (op_r == OP_ENTER) begin
          if (live_r == LIVE_FULL) begin
            status_nxt    = ST_FULL;
            res_round_nxt = '0;
            state_nxt     = S_DONE;
          end else begin
            ram_rd_en   = (live_r != '0);
            ram_rd_addr = newest_slot_r;
            state_nxt   = S_ENT_WR;
          end
        end else begin
          res_round_nxt = entered_r;
          if (ofs < ROUND_W'(live_r)) begin
            rem_nxt      = live_r;
            skip_nxt     = ofs[LW-1:0];
            wk_round_nxt = oldest_r;
            wk_slot_nxt  = oldest_slot_r;
            pend_nxt     = 1'b0;
            state_nxt    = S_WALK;
          end else begin
            status_nxt = ST_NOT_LIVE;
            state_nxt  = S_DONE;
          end
        end
      end

      // new round count = previous newest count + 1, saturating
      S_ENT_WR: begin
        alu_inc         = 1'b1;
        alu_a           = (live_r == '0) ? '0 : ram_rd_data;
        ram_wr_en       = 1'b1;
        ram_wr_addr     = slot_step(newest_r, newest_slot_r);
        newest_nxt      = newest_r + 1'b1;
        newest_slot_nxt = slot_step(newest_r, newest_slot_r);
        live_nxt        = live_r + 1'b1;
        res_round_nxt   = newest_r + 1'b1;
        state_nxt       = S_DONE;
      end

      // walk live slots from the oldest; read one, write back the previous
      S_WALK: begin
        if (pend_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = pend_slot_r;
          if (alu_clip) begin
            status_nxt = ST_UNDERFLOW;
          end
        end
        if (rem_r != '0) begin
          rem_nxt      = rem_r - 1'b1;
          wk_round_nxt = wk_round_r + 1'b1;
          wk_slot_nxt  = slot_step(wk_round_r, wk_slot_r);
          if (skip_r != '0) begin
            skip_nxt = skip_r - 1'b1;
            pend_nxt = 1'b0;
          end else begin
            ram_rd_en     = 1'b1;
            ram_rd_addr   = wk_slot_r;
            pend_nxt      = 1'b1;
            pend_slot_nxt = wk_slot_r;
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_RET_RD;
        end
      end

      S_RET_RD: begin
        if (retired_r < RET_LIMIT && live_r != '0) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = oldest_slot_r;
          state_nxt   = S_RET_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // retire the oldest round when its count is zero
      S_RET_CHK: begin
        if (ram_rd_data == '0) begin
          oldest_nxt      = oldest_r + 1'b1;
          oldest_slot_nxt = slot_step(oldest_r, oldest_slot_r);
          live_nxt        = live_r - 1'b1;
          retired_nxt     = retired_r + 1'b1;
          state_nxt       = S_RET_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_round_nxt   = res_round_r;
          out_status_nxt  = status_r;
          out_retired_nxt = RETIRED_W'(retired_r);
          out_oldest_nxt  = oldest_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    ram_wr_data = alu_y;
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      op_r            <= OP_ENTER;
      entered_r       <= '0;
      newest_r        <= '0;
      oldest_r        <= ROUND_W'(1);
      newest_slot_r   <= '0;
      oldest_slot_r   <= SW'(1);
      live_r          <= '0;
      wk_round_r      <= '0;
      wk_slot_r       <= '0;
      rem_r           <= '0;
      skip_r          <= '0;
      pend_r          <= 1'b0;
      pend_slot_r     <= '0;
      res_round_r     <= '0;
      status_r        <= ST_OK;
      retired_r       <= '0;
      out_valid_r     <= 1'b0;
      out_round_r     <= '0;
      out_status_r    <= ST_OK;
      out_retired_r   <= '0;
      out_oldest_r    <= '0;
    end else begin
      state_r         <= state_nxt;
      op_r            <= op_nxt;
      entered_r       <= entered_nxt;
      newest_r        <= newest_nxt;
      oldest_r        <= oldest_nxt;
      newest_slot_r   <= newest_slot_nxt;
      oldest_slot_r   <= oldest_slot_nxt;
      live_r          <= live_nxt;
      wk_round_r      <= wk_round_nxt;
      wk_slot_r       <= wk_slot_nxt;
      rem_r           <= rem_nxt;
      skip_r          <= skip_nxt;
      pend_r          <= pend_nxt;
      pend_slot_r     <= pend_slot_nxt;
      res_round_r     <= res_round_nxt;
      status_r        <= status_nxt;
      retired_r       <= retired_nxt;
      out_valid_r     <= out_valid_nxt;
      out_round_r     <= out_round_nxt;
      out_status_r    <= out_status_nxt;
      out_retired_r   <= out_retired_nxt;
      out_oldest_r    <= out_oldest_nxt;
    end
  end

  assign in_stall              = (state_r != S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_round_id          = out_round_r;
  assign out_status            = out_status_r;
  assign out_rounds_retired    = out_retired_r;
  assign out_oldest_live_round = out_oldest_r;

  // live count tracks the round span
  a_live_span: assert property (@(posedge clk) disable iff (!rst_n)
    (newest_r - oldest_r + ROUND_W'(1)) == ROUND_W'(live_r))
    else $error("live count out of step with round span");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LIVE_FULL)
    else $error("more live rounds than ring slots");

  a_retire_bound: assert property (@(posedge clk) disable iff (!rst_n)
    retired_r <= RET_LIMIT)
    else $error("retire burst exceeded its limit");

  // walk writes never target the slot being read
  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_rd_en && ram_wr_en) |-> (ram_rd_addr != ram_wr_addr))
    else $error("count RAM read and write to the same slot");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CHECK))
    else $error("accepted request did not start processing");

endmodule

`default_nettype wire

// File: src/ert_count_ram.sv
// Single-port-read, single-port-write RAM holding the per-slot use counts.
// Depends on ert_pkg for the count width.
`default_nettype none

module ert_count_ram #(
  parameter int DEPTH = ert_pkg::ROUNDS_DEF,
  parameter int AW    = $clog2(ert_pkg::ROUNDS_DEF)
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [ert_pkg::COUNT_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [ert_pkg::COUNT_W-1:0] wr_data
);
  import ert_pkg::*;

  logic [COUNT_W-1:0] mem [DEPTH];
  logic [COUNT_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds its value between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
